>>> hw/rtl/lpsc_pkg.sv
// Shared types and constants for the lidar point stereo projection block.
package lpsc_pkg;

  localparam int NUM_COEF  = 24;
  localparam int COEF_W    = 32;
  localparam int PT_W      = 20;
  localparam int SIZE_W    = 13;
  localparam int PIX_W     = 12;
  localparam int PROD_W    = 54;
  localparam int QUO_W     = 13;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;
  localparam int IN_W      = 8 * ((1 + IDX_W + COEF_W + 3 * PT_W + 7) / 8);
  localparam int OUT_W     = 8 * ((3 + 4 * PIX_W + 7) / 8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_Z_MIN  = 3'd4,
    REG_Z_MAX  = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } cfg_reg_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef struct packed {
    logic             visible;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } cam_result_t;

endpackage

>>> hw/rtl/lpsc_divider.sv
// Pipelined signed quotient of a 54-bit numerator by a positive divisor, 13 result bits.
module lpsc_divider #(
  parameter int STEPS = 13
) (
  input  logic                                   clk,
  input  logic                                   advance,
  input  logic                                   in_ok,
  input  logic signed [lpsc_pkg::PROD_W-1:0]     num,
  input  logic signed [lpsc_pkg::PROD_W-1:0]     den,
  output logic                                   out_ok,
  output logic                                   out_neg,
  output logic [lpsc_pkg::PROD_W-1:0]            out_quo
);
  localparam int W = lpsc_pkg::PROD_W;

  // ok: quotient magnitude fits below 2^STEPS; computed one bit per stage
  logic [W-1:0] rem  [STEPS+1];
  logic [W-1:0] dv   [STEPS+1];
  logic [W-1:0] quo  [STEPS+1];
  logic         neg  [STEPS+1];
  logic         ok   [STEPS+1];
  logic [W-1:0] mag;

  assign mag = num[W-1] ? W'(-num) : W'(num);

  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0] <= mag;
      dv[0]  <= W'(den);
      quo[0] <= '0;
      neg[0] <= num[W-1];
      ok[0]  <= in_ok && ((mag >> STEPS) < W'(den));
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int SH = STEPS - 1 - s;
    logic [W+STEPS-1:0] trial;
    logic               take;
    assign trial = (W+STEPS)'(dv[s]) << SH;
    assign take  = (W+STEPS)'(rem[s]) >= trial;
    always_ff @(posedge clk) begin
      if (advance) begin
        rem[s+1] <= take ? W'((W+STEPS)'(rem[s]) - trial) : rem[s];
        quo[s+1] <= quo[s] | (W'(take) << SH);
        dv[s+1]  <= dv[s];
        neg[s+1] <= neg[s];
        ok[s+1]  <= ok[s];
      end
    end
  end

  assign out_ok  = ok[STEPS];
  assign out_neg = neg[STEPS] && (quo[STEPS] != '0);
  assign out_quo = quo[STEPS];
endmodule

>>> hw/rtl/lidar_point_stereo_camera_projection.sv
// Top level: box test, two 3x4 projections and pipelined divisions per point.
//
// One item enters every cycle while the output is not stalled; each result passes
// through the box test, coefficient multiply, row sums, divider input register,
// 13 divider stages and the output register. Stall on the output freezes the
// whole pipeline. A load item writes its coefficient when it is accepted; a point
// accepted afterwards sees it. Coefficients are undefined until written.
module lidar_point_stereo_camera_projection #(
  parameter int MAX_IMAGE_SIZE = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // kind, coef_index, coef_value, point_x, point_y, point_z
  input  logic [lpsc_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // in_region, left_visible, left_col, left_row, right_visible, right_col, right_row
  output logic [lpsc_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_we,
  input  logic [lpsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpsc_pkg::CFG_W-1:0]    cfg_data
);
  localparam int PW  = lpsc_pkg::PT_W;
  localparam int CW  = lpsc_pkg::COEF_W;
  localparam int DW  = lpsc_pkg::PROD_W;
  localparam int SW  = lpsc_pkg::SIZE_W;
  localparam int MSW = $clog2(MAX_IMAGE_SIZE + 1);
  localparam int NS  = lpsc_pkg::QUO_W;
  localparam int LAT = 5 + NS;

  logic signed [PW-1:0] x_min, x_max, y_min, y_max, z_min, z_max;
  logic [SW-1:0] img_w, img_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= PW'(10240);  x_max <= PW'(53248);
      y_min <= -PW'(24576); y_max <= PW'(24576);
      z_min <= -PW'(4506);  z_max <= '0;
      img_w <= SW'(640);    img_h <= SW'(480);
    end else if (cfg_we) begin
      case (lpsc_pkg::cfg_reg_t'(cfg_index))
        lpsc_pkg::REG_X_MIN:  x_min <= cfg_data;
        lpsc_pkg::REG_X_MAX:  x_max <= cfg_data;
        lpsc_pkg::REG_Y_MIN:  y_min <= cfg_data;
        lpsc_pkg::REG_Y_MAX:  y_max <= cfg_data;
        lpsc_pkg::REG_Z_MIN:  z_min <= cfg_data;
        lpsc_pkg::REG_Z_MAX:  z_max <= cfg_data;
        lpsc_pkg::REG_WIDTH:  img_w <= SW'(cfg_data);
        lpsc_pkg::REG_HEIGHT: img_h <= SW'(cfg_data);
        default: ;
      endcase
    end
  end

  logic [MSW-1:0] lim_w, lim_h;
  assign lim_w = (32'(img_w) > MAX_IMAGE_SIZE) ? MSW'(MAX_IMAGE_SIZE) : MSW'(img_w);
  assign lim_h = (32'(img_h) > MAX_IMAGE_SIZE) ? MSW'(MAX_IMAGE_SIZE) : MSW'(img_h);

  // input fields
  logic                          kind;
  logic [lpsc_pkg::IDX_W-1:0]    cidx;
  logic signed [CW-1:0]          cval;
  logic signed [PW-1:0]          px, py, pz;
  assign kind = s_tdata[0];
  assign cidx = s_tdata[5:1];
  assign cval = s_tdata[37:6];
  assign px   = s_tdata[57:38];
  assign py   = s_tdata[77:58];
  assign pz   = s_tdata[97:78];

  // pipeline advance: the whole pipe moves unless the output register is held
  logic adv;
  logic [LAT-1:0] vld;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic acc_in;
  assign acc_in = s_tvalid && s_tready;

  logic signed [CW-1:0] coef [lpsc_pkg::NUM_COEF];
  always_ff @(posedge clk) begin
    if (acc_in && kind == lpsc_pkg::KIND_LOAD && cidx < lpsc_pkg::IDX_W'(lpsc_pkg::NUM_COEF))
      coef[cidx] <= cval;
  end

  // stage 1: box test, capture point
  logic s1_reg;
  logic signed [PW-1:0] s1_x, s1_y, s1_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_reg <= s_tvalid && kind == lpsc_pkg::KIND_POINT &&
                px >= x_min && px <= x_max && py >= y_min && py <= y_max &&
                pz >= z_min && pz <= z_max;
      s1_x <= px; s1_y <= py; s1_z <= pz;
    end
  end

  // stage 2: four terms per camera row, three products and the shifted constant
  logic signed [DW-1:0] s2_p [2][3][4];
  logic s2_reg;
  for (genvar c = 0; c < 2; c++) begin : g_cam
    for (genvar r = 0; r < 3; r++) begin : g_row
      always_ff @(posedge clk) begin
        if (adv) begin
          s2_p[c][r][0] <= DW'(coef[c*12+r*4+0] * s1_x);
          s2_p[c][r][1] <= DW'(coef[c*12+r*4+1] * s1_y);
          s2_p[c][r][2] <= DW'(coef[c*12+r*4+2] * s1_z);
          s2_p[c][r][3] <= DW'(coef[c*12+r*4+3]) <<< 12;
        end
      end
    end
  end
  always_ff @(posedge clk) if (adv) s2_reg <= s1_reg;

  // stage 3: row sums
  logic signed [DW-1:0] s3_s [2][3];
  logic s3_reg;
  for (genvar c = 0; c < 2; c++) begin : g_sum
    for (genvar r = 0; r < 3; r++) begin : g_r
      always_ff @(posedge clk)
        if (adv) s3_s[c][r] <= s2_p[c][r][0] + s2_p[c][r][1] + s2_p[c][r][2] + s2_p[c][r][3];
    end
  end
  always_ff @(posedge clk) if (adv) s3_reg <= s2_reg;

  // stage 4: positive depth; feed dividers (divisor forced to 1 when not used)
  logic d_ok [2][2];
  logic d_neg [2][2];
  logic [DW-1:0] d_q [2][2];
  logic s_reg [NS+1];
  always_ff @(posedge clk) if (adv) s_reg[0] <= s3_reg;
  for (genvar k = 1; k <= NS; k++) begin : g_dly
    always_ff @(posedge clk) if (adv) s_reg[k] <= s_reg[k-1];
  end
  for (genvar c = 0; c < 2; c++) begin : g_div
    logic pos;
    logic signed [DW-1:0] den;
    assign pos = s3_reg && s3_s[c][2] > 0;
    assign den = pos ? s3_s[c][2] : DW'(1);
    for (genvar r = 0; r < 2; r++) begin : g_d
      lpsc_divider #(.STEPS(NS)) u_div (
        .clk(clk), .advance(adv), .in_ok(pos),
        .num(s3_s[c][r]), .den(den),
        .out_ok(d_ok[c][r]), .out_neg(d_neg[c][r]), .out_quo(d_q[c][r])
      );
    end
  end

  // final check and output register
  lpsc_pkg::cam_result_t res [2];
  for (genvar c = 0; c < 2; c++) begin : g_res
    logic v;
    assign v = d_ok[c][0] && d_ok[c][1] && !d_neg[c][0] && !d_neg[c][1] &&
               d_q[c][0] < DW'(lim_w) && d_q[c][1] < DW'(lim_h);
    assign res[c].visible = v;
    assign res[c].col = v ? lpsc_pkg::PIX_W'(d_q[c][0]) : '0;
    assign res[c].row = v ? lpsc_pkg::PIX_W'(d_q[c][1]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], acc_in};
  end
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= lpsc_pkg::OUT_W'({res[1].row, res[1].col, res[1].visible,
                                   res[0].row, res[0].col, res[0].visible, s_reg[NS]});
    end
  end

  a_vis_needs_region: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1] || m_tdata[26]) |-> m_tdata[0])
    else $error("visible without region");
  a_col_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[25:2] == 24'd0)
    else $error("left fields set while not visible");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(vld))
    else $error("pipeline moved during stall");
endmodule

>>> dv/tb_top.sv
// Testbench for the lidar point stereo camera projection block.
`timescale 1ns / 100ps

import lpsc_pkg::*;

class proj_scoreboard;
  logic signed [PT_W-1:0] box_lo [3];
  logic signed [PT_W-1:0] box_hi [3];
  logic [SIZE_W-1:0] img_w, img_h;
  logic [COEF_W-1:0] coef [NUM_COEF];
  logic [OUT_W-1:0] pending [$];
  int errors;

  function new();
    box_lo[0] = PT_W'(10240);  box_hi[0] = PT_W'(53248);
    box_lo[1] = PT_W'(-24576); box_hi[1] = PT_W'(24576);
    box_lo[2] = PT_W'(-4506);  box_hi[2] = '0;
    img_w = SIZE_W'(640); img_h = SIZE_W'(480);
    errors = 0;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_X_MIN: box_lo[0] = v;
      REG_X_MAX: box_hi[0] = v;
      REG_Y_MIN: box_lo[1] = v;
      REG_Y_MAX: box_hi[1] = v;
      REG_Z_MIN: box_lo[2] = v;
      REG_Z_MAX: box_hi[2] = v;
      REG_WIDTH: img_w = v[SIZE_W-1:0];
      REG_HEIGHT: img_h = v[SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  function longint clamp_size(logic [SIZE_W-1:0] s);
    longint v;
    v = longint'(s);
    if (v > 4096) v = 4096;
    return v;
  endfunction

  function longint row_sum(int cam, int r, longint px, longint py, longint pz);
    int b;
    longint acc;
    b = cam * 12 + r * 4;
    acc = longint'($signed(coef[b + 3])) * 4096;
    acc += longint'($signed(coef[b])) * px;
    acc += longint'($signed(coef[b + 1])) * py;
    acc += longint'($signed(coef[b + 2])) * pz;
    return acc;
  endfunction

  function cam_result_t project(int cam, longint px, longint py, longint pz);
    cam_result_t res;
    longint u, v, w, cq, rq;
    res = '0;
    u = row_sum(cam, 0, px, py, pz);
    v = row_sum(cam, 1, px, py, pz);
    w = row_sum(cam, 2, px, py, pz);
    if (w <= 0) return res;
    cq = u / w;
    rq = v / w;
    if (cq >= 0 && cq < clamp_size(img_w) && rq >= 0 && rq < clamp_size(img_h)) begin
      res.visible = 1'b1;
      res.col = cq[PIX_W-1:0];
      res.row = rq[PIX_W-1:0];
    end
    return res;
  endfunction

  function void note_item(logic [IN_W-1:0] d);
    logic [OUT_W-1:0] exp_out;
    logic signed [PT_W-1:0] p [3];
    cam_result_t lc, rc;
    logic [IDX_W-1:0] idx;
    bit in_box;
    exp_out = '0;
    idx = d[IDX_W:1];
    if (d[0] == KIND_LOAD) begin
      if (idx < NUM_COEF) coef[idx] = d[IDX_W+COEF_W:IDX_W+1];
    end else begin
      for (int i = 0; i < 3; i++) p[i] = d[38 + i * PT_W +: PT_W];
      in_box = 1'b1;
      for (int i = 0; i < 3; i++)
        if (p[i] < box_lo[i] || p[i] > box_hi[i]) in_box = 1'b0;
      if (in_box) begin
        lc = project(0, longint'(p[0]), longint'(p[1]), longint'(p[2]));
        rc = project(1, longint'(p[0]), longint'(p[1]), longint'(p[2]));
        exp_out[0] = 1'b1;
        exp_out[1] = lc.visible;
        exp_out[13:2] = lc.col;
        exp_out[25:14] = lc.row;
        exp_out[26] = rc.visible;
        exp_out[38:27] = rc.col;
        exp_out[50:39] = rc.row;
      end
    end
    pending = {pending, exp_out};
  endfunction

  function void check_result(logic [OUT_W-1:0] got);
    logic [OUT_W-1:0] exp_out;
    string names [7];
    int lsb [7];
    int wid [7];
    names = '{"in_region", "left_visible", "left_col", "left_row",
              "right_visible", "right_col", "right_row"};
    lsb = '{0, 1, 2, 14, 26, 27, 39};
    wid = '{1, 1, 12, 12, 1, 12, 12};
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result %h", $time, got);
      return;
    end
    exp_out = pending.pop_front();
    for (int i = 0; i < 7; i++)
      if (((exp_out >> lsb[i]) & ((1 << wid[i]) - 1)) !==
          ((got >> lsb[i]) & ((1 << wid[i]) - 1))) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, names[i],
                 (exp_out >> lsb[i]) & ((1 << wid[i]) - 1),
                 (got >> lsb[i]) & ((1 << wid[i]) - 1));
      end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_cycles = 0;
  logic [CFG_W-1:0] box_cfg [8];
  int cam_base [NUM_COEF];
  proj_scoreboard sb;

  lidar_point_stereo_camera_projection u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      m_tready <= 1'b0;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  function automatic logic [IN_W-1:0] load_item(logic [IDX_W-1:0] idx,
                                                 logic [COEF_W-1:0] val);
    logic [IN_W-1:0] d;
    d = '0;
    d[0] = KIND_LOAD;
    d[IDX_W:1] = idx;
    d[IDX_W+COEF_W:IDX_W+1] = val;
    d[IN_W-7:38] = (3 * PT_W)'({$urandom(), $urandom()});
    return d;
  endfunction

  function automatic logic [IN_W-1:0] point_item(int x, int y, int z);
    logic [IN_W-1:0] d;
    d = '0;
    d[0] = KIND_POINT;
    d[IDX_W:1] = IDX_W'($urandom());
    d[IDX_W+COEF_W:IDX_W+1] = $urandom();
    d[57:38] = PT_W'(x);
    d[77:58] = PT_W'(y);
    d[97:78] = PT_W'(z);
    return d;
  endfunction

  function automatic logic [IN_W-1:0] random_item();
    int r, idx;
    r = $urandom_range(99);
    if (r < 4) begin
      idx = $urandom_range(NUM_COEF - 1);
      return load_item(IDX_W'(idx), cam_base[idx] + int'($urandom_range(8192)) - 4096);
    end
    if (r < 6) return load_item(IDX_W'($urandom_range(31, NUM_COEF)), $urandom());
    if (r < 7) return load_item(IDX_W'($urandom_range(NUM_COEF - 1)), $urandom());
    if (r < 30) return point_item($urandom(), $urandom(), $urandom());
    return point_item(int'($urandom_range(250000)) - 8000,
                      int'($urandom_range(100000)) - 50000,
                      int'($urandom_range(20000)) - 10000);
  endfunction

  task automatic send(logic [IN_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic apply_config();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= box_cfg[i];
      sb.set_reg(cfg_reg_t'(i), box_cfg[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_config(int sel);
    int lo;
    lo = $urandom_range(20000);
    box_cfg[0] = CFG_W'(lo);
    box_cfg[1] = CFG_W'(lo + $urandom_range(200000));
    box_cfg[2] = CFG_W'(-int'($urandom_range(40000)));
    box_cfg[3] = CFG_W'($urandom_range(40000));
    box_cfg[4] = CFG_W'(-int'($urandom_range(8000)));
    box_cfg[5] = CFG_W'($urandom_range(8000));
    box_cfg[6] = CFG_W'($urandom_range(1200, 1));
    box_cfg[7] = CFG_W'($urandom_range(1000, 1));
    case (sel)
      0: begin
        box_cfg[0] = 20'h80000; box_cfg[1] = 20'h7FFFF;
        box_cfg[2] = 20'h80000; box_cfg[3] = 20'h7FFFF;
        box_cfg[4] = 20'h80000; box_cfg[5] = 20'h7FFFF;
        box_cfg[6] = CFG_W'(8191); box_cfg[7] = CFG_W'(4096);
      end
      1: begin box_cfg[6] = CFG_W'(1); box_cfg[7] = CFG_W'(1); end
      2: begin box_cfg[6] = '0; box_cfg[7] = CFG_W'(4097); end
      3: begin box_cfg[0] = CFG_W'(60000); box_cfg[1] = CFG_W'(59999); end
      4: begin box_cfg[6] = CFG_W'(4096); box_cfg[7] = '0; box_cfg[5] = 20'h7FFFF; end
      default: ;
    endcase
  endtask

  initial begin
    logic [IN_W-1:0] directed [$];
    int base_rows [12];
    sb = new();
    base_rows = '{320, -500, 0, 0, 240, 0, -500, 0, 1, 0, 0, 0};
    for (int i = 0; i < NUM_COEF; i++) cam_base[i] = base_rows[i % 12] * 65536;
    cam_base[15] = -250 * 65536;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_COEF; i++) send(load_item(IDX_W'(i), cam_base[i]));
    for (int i = 0; i < 150; i++) send(random_item());
    drain();

    pick_config(0);
    apply_config();
    directed = '{point_item(0, 0, 0), point_item(-4096, 100, 100),
                 point_item(524287, 524287, 524287),
                 point_item(-524288, -524288, -524288),
                 point_item(524287, 0, 0), point_item(40960, -1, 1),
                 point_item(40960, 4096, 0), point_item(4096, 20000, 0),
                 load_item(IDX_W'(24), 32'h80000000),
                 load_item(IDX_W'(31), 32'h7FFFFFFF),
                 load_item(IDX_W'(27), 32'hFFFFFFFF), point_item(40960, 0, 0),
                 load_item(IDX_W'(3), 32'h7FFFFFFF), point_item(40960, 0, 0),
                 load_item(IDX_W'(3), 32'h80000000), point_item(40960, 0, 0),
                 load_item(IDX_W'(3), cam_base[3]), point_item(40960, 41000, 0),
                 point_item(40960, -20, 0), point_item(8192, 0, 2000)};
    foreach (directed[i]) send(directed[i]);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      pick_config(ph + 1);
      apply_config();
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (ph == 4) begin
        send_idle_pct = 0;
        holdoff_cycles = 300;
      end
      for (int i = 0; i < 195; i++) send(random_item());
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
